### src/av1re_pkg.sv
// av1re_pkg: shared types and constants of the multi-symbol range encoder
// used by av1re_rbuf and av1_multisymbol_range_encoder_unit; no dependencies
package av1re_pkg;

  localparam int RESULT_LIMIT = 20;
  localparam int RUN_DEPTH    = RESULT_LIMIT - 1;

  typedef enum logic [1:0] {
    KIND_SYM = 2'd0,
    KIND_LIT = 2'd1,
    KIND_FIN = 2'd2,
    KIND_RST = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_INVALID  = 2'd1,
    ST_OVERFLOW = 2'd2,
    ST_SMALL    = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    REG_SIZING   = 1'd0,
    REG_CAPACITY = 1'd1
  } reg_idx_t;

  localparam logic [15:0] PROB_TOP   = 16'h8000;
  localparam logic [15:0] RANGE_INIT = 16'h8000;
  localparam logic [6:0]  CNT_INIT   = 7'h77;      // minus nine
  localparam logic [63:0] FIN_MASK   = 64'h3fff;
  localparam logic [7:0]  NORM_LIMIT = 8'd40;
  localparam logic [7:0]  BYTE_SLACK = 8'd24;
  localparam logic [7:0]  FIN_SLACK  = 8'd10;
  localparam logic [9:0]  HALF_PROB  = 10'd256;    // 16384 >> 6
  localparam logic [6:0]  MIN_PROB   = 7'd4;
  localparam logic [7:0]  BYTE_FF    = 8'hff;

  typedef struct packed {
    logic [7:0]  byte_v;
    logic [15:0] cnt;
  } run_t;

  typedef struct packed {
    logic        we;
    logic [7:0]  byte_v;
    logic [15:0] cnt;
  } run_wr_t;

endpackage

### src/av1re_mul.sv
// av1re_mul: shared scaled multiply unit, q = ((a * b) >> 1) + k, registered
// no dependencies
module av1re_mul (
  input  logic        clk,
  input  logic [7:0]  a,
  input  logic [9:0]  b,
  input  logic [6:0]  k,
  output logic [16:0] q_r
);

  logic [17:0] prod;

  assign prod = {10'b0, a} * {8'b0, b};

  always_ff @(posedge clk) begin
    q_r <= prod[17:1] + {10'b0, k};
  end

endmodule

### src/av1re_rbuf.sv
// av1re_rbuf: queue of byte runs collected for one request
// depends on av1re_pkg
module av1re_rbuf #(
  parameter int DEPTH = 19,
  localparam int IDX_W = $clog2(DEPTH)
) (
  input  logic                 clk,
  input  av1re_pkg::run_wr_t   wr,
  input  logic [IDX_W-1:0]     wr_idx,
  input  logic [IDX_W-1:0]     rd_idx,
  output av1re_pkg::run_t      rd_data
);
  import av1re_pkg::*;

  run_t mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem_r[wr_idx] <= '{byte_v: wr.byte_v, cnt: wr.cnt};
    end
  end

  assign rd_data = mem_r[rd_idx];

endmodule

### src/av1_multisymbol_range_encoder_unit.sv
// av1_multisymbol_range_encoder_unit: top level of the multi-symbol range encoder
// depends on av1re_pkg, av1re_mul, av1re_rbuf
//
// One request is taken at a time; in_ready is low until its last result has
// been taken. A symbol uses the shared multiply unit in S_SYM_U and S_SYM_L,
// then S_SYM_C and S_NORM; when bytes are ready, S_EXTR and S_ROOM follow and
// each released byte passes S_PUT. A literal runs S_BOOL, S_BOOL_C and S_NORM
// per bit, plus the same for bytes; a finish runs S_FIN, S_FIN_LOOP per byte,
// then S_FIN_END and S_FIN_END2. Byte runs are collected and delivered after
// the request, followed by a status result with last set.
module av1_multisymbol_range_encoder_unit #(
  parameter int MAX_FF_RUN  = 65535,
  parameter int MAX_SYMBOLS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [31:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [3:0]  in_symbol_index,
  input  logic [4:0]  in_alphabet_size,
  input  logic [15:0] in_cdf_below,
  input  logic [15:0] in_cdf_at,
  input  logic [31:0] in_literal_value,
  input  logic [5:0]  in_literal_bits,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_byte_value,
  output logic [15:0] out_repeat_count,
  output logic [1:0]  out_status,
  output logic [31:0] out_byte_position,
  output logic        out_last
);
  import av1re_pkg::*;

  localparam int IDX_W = $clog2(RUN_DEPTH);
  localparam int CNT_W = $clog2(RUN_DEPTH + 1);

  typedef enum logic [17:0] {
    S_IDLE     = 18'h00001,
    S_SYM_U    = 18'h00002,
    S_SYM_L    = 18'h00004,
    S_SYM_C    = 18'h00008,
    S_BOOL     = 18'h00010,
    S_BOOL_C   = 18'h00020,
    S_NORM     = 18'h00040,
    S_EXTR     = 18'h00080,
    S_ROOM     = 18'h00100,
    S_CARRY    = 18'h00200,
    S_CARRY2   = 18'h00400,
    S_PUT      = 18'h00800,
    S_PUT2     = 18'h01000,
    S_FIN      = 18'h02000,
    S_FIN_LOOP = 18'h04000,
    S_FIN_END  = 18'h08000,
    S_FIN_END2 = 18'h10000,
    S_OUT      = 18'h20000
  } state_t;

  state_t st_r, st_nxt;

  logic        sizing_r;
  logic [31:0] cap_r;

  logic [63:0] low_r, low_nxt;
  logic [15:0] rng_r, rng_nxt;
  logic [6:0]  cnt_r, cnt_nxt;
  logic [31:0] pos_r, pos_nxt;
  status_t     err_r, err_nxt;
  logic        fin_r, fin_nxt;
  logic [7:0]  held_r, held_nxt;
  logic        hv_r, hv_nxt;
  logic [15:0] ff_r, ff_nxt;

  kind_t       kind_r, kind_nxt;
  logic [3:0]  idx_r, idx_nxt;
  logic [4:0]  alpha_r, alpha_nxt;
  logic [15:0] below_r, below_nxt;
  logic [15:0] at_r, at_nxt;
  logic [31:0] lit_r, lit_nxt;
  logic [5:0]  lb_r, lb_nxt;

  logic [63:0] wl_r, wl_nxt;
  logic [17:0] wr_r, wr_nxt;
  logic [16:0] su_r, su_nxt;
  logic [3:0]  shift_r, shift_nxt;
  logic [2:0]  ready_r, ready_nxt;
  logic [4:0]  count_r, count_nxt;
  logic [7:0]  npend_r, npend_nxt;
  logic [63:0] t_r, t_nxt;
  logic [2:0]  bi_r, bi_nxt;
  logic [7:0]  fbyte_r, fbyte_nxt;
  logic [7:0]  fcnt_r, fcnt_nxt;
  logic [7:0]  fpend_r, fpend_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [CNT_W-1:0] rd_r, rd_nxt;

  // shared multiply unit
  logic [9:0]  mul_b;
  logic [6:0]  mul_k;
  logic [16:0] mul_q;

  av1re_mul u_mul (
    .clk (clk),
    .a   (rng_r[15:8]),
    .b   (mul_b),
    .k   (mul_k),
    .q_r (mul_q)
  );

  run_wr_t run_wr;
  run_t    run_rd;

  av1re_rbuf #(.DEPTH(RUN_DEPTH)) u_rbuf (
    .clk     (clk),
    .wr      (run_wr),
    .wr_idx  (n_r[IDX_W-1:0]),
    .rd_idx  (rd_r[IDX_W-1:0]),
    .rd_data (run_rd)
  );

  // symbol operands
  logic [4:0]  alpha_m1;
  logic [3:0]  lmi;
  logic [15:0] upper, lower;

  assign alpha_m1 = alpha_r - 5'd1;
  assign lmi      = alpha_m1[3:0] - idx_r;
  assign upper    = PROB_TOP - at_r;
  assign lower    = PROB_TOP - below_r;

  always_comb begin
    unique case (st_r)
      S_SYM_U: begin
        mul_b = upper[15:6];
        mul_k = {1'b0, lmi, 2'b00};
      end
      S_SYM_L: begin
        mul_b = lower[15:6];
        mul_k = {({1'b0, lmi} + 5'd1), 2'b00};
      end
      default: begin
        mul_b = HALF_PROB;
        mul_k = MIN_PROB;
      end
    endcase
  end

  // leading zero count of the new range
  logic [3:0] fl_c, sh_c;
  always_comb begin
    fl_c = 4'd0;
    for (int i = 0; i < 16; i++) begin
      if (wr_r[i]) fl_c = 4'(i);
    end
    sh_c = 4'd15 - fl_c;
  end

  logic [7:0]  pend_c, count_c, pend_f, pend_f7;
  logic [2:0]  ready_c, bytes_f, sel_i, room_bytes;
  logic [5:0]  sh_f;
  logic [63:0] t_sh, f_sh, mask_c, mask_f, fin_end;
  logic [15:0] fval;
  logic [7:0]  put_v;
  logic [32:0] room_end;
  logic        room_ovf, room_small, can_carry, range_bad;
  logic [17:0] d_rs, d_ss, d_ru, d_rsp;

  assign pend_c   = {cnt_r[6], cnt_r} + {4'b0, sh_c};
  assign ready_c  = pend_c[5:3] + 3'd1;
  assign count_c  = {cnt_r[6], cnt_r} + BYTE_SLACK - {2'b0, ready_c, 3'b000};
  assign pend_f   = {cnt_r[6], cnt_r} + FIN_SLACK;
  assign pend_f7  = pend_f + 8'd7;
  assign bytes_f  = (!pend_f[7] && pend_f != 8'd0) ? pend_f7[5:3] : 3'd0;
  assign sh_f     = fcnt_r[5:0] + 6'd16;
  assign sel_i    = ready_r - 3'd1 - bi_r;
  assign t_sh     = t_r >> {sel_i, 3'b000};
  assign f_sh     = t_r >> sh_f;
  assign fval     = f_sh[15:0];
  assign mask_c   = (64'd1 << count_r) - 64'd1;
  assign mask_f   = (64'd1 << sh_f) - 64'd1;
  assign fin_end  = ((low_r + FIN_MASK) & ~FIN_MASK) | (FIN_MASK + 64'd1);
  assign put_v    = (kind_r == KIND_FIN) ? fbyte_r : t_sh[7:0];
  assign room_bytes = (st_r == S_FIN) ? bytes_f : ready_r;
  assign room_end   = {1'b0, pos_r} + {30'b0, room_bytes};
  assign room_ovf   = room_end[32];
  assign room_small = !sizing_r && (room_end[31:0] > cap_r);
  assign can_carry  = sizing_r || (hv_r && held_r != BYTE_FF);
  assign range_bad  = wr_r[17] || wr_r[16] || (wr_r[15:0] == 16'd0);
  assign d_rs  = {2'b0, rng_r} - {1'b0, mul_q};
  assign d_ss  = {1'b0, mul_q} - {1'b0, su_r};
  assign d_ru  = {2'b0, rng_r} - {1'b0, su_r};
  assign d_rsp = {2'b0, rng_r} - {1'b0, mul_q};

  // request checks
  logic sym_bad, lit_bad;
  logic [31:0] lit_hi;
  assign lit_hi  = in_literal_value >> in_literal_bits;
  assign sym_bad = fin_r || in_alphabet_size < 5'd2 ||
                   in_alphabet_size > 5'(MAX_SYMBOLS) ||
                   {1'b0, in_symbol_index} >= in_alphabet_size ||
                   in_cdf_at > PROB_TOP ||
                   (in_symbol_index != 4'd0 &&
                    (in_cdf_below > PROB_TOP || in_cdf_below > in_cdf_at)) ||
                   ({1'b0, in_symbol_index} + 5'd1 == in_alphabet_size &&
                    in_cdf_at != PROB_TOP);
  assign lit_bad = fin_r || in_literal_bits > 6'd32 ||
                   (in_literal_bits != 6'd0 && in_literal_bits < 6'd32 &&
                    lit_hi != 32'd0);

  logic    fail_req;
  status_t fail_code;
  logic    em_we;
  logic [7:0]  em_byte;
  logic [15:0] em_cnt;
  logic    cm_fire, cm_norm, adv;
  logic [3:0] cm_sh;

  always_comb begin
    st_nxt    = st_r;
    low_nxt   = low_r;
    rng_nxt   = rng_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    err_nxt   = err_r;
    fin_nxt   = fin_r;
    held_nxt  = held_r;
    hv_nxt    = hv_r;
    ff_nxt    = ff_r;
    kind_nxt  = kind_r;
    idx_nxt   = idx_r;
    alpha_nxt = alpha_r;
    below_nxt = below_r;
    at_nxt    = at_r;
    lit_nxt   = lit_r;
    lb_nxt    = lb_r;
    wl_nxt    = wl_r;
    wr_nxt    = wr_r;
    su_nxt    = su_r;
    shift_nxt = shift_r;
    ready_nxt = ready_r;
    count_nxt = count_r;
    npend_nxt = npend_r;
    t_nxt     = t_r;
    bi_nxt    = bi_r;
    fbyte_nxt = fbyte_r;
    fcnt_nxt  = fcnt_r;
    fpend_nxt = fpend_r;
    n_nxt     = n_r;
    rd_nxt    = rd_r;
    fail_req  = 1'b0;
    fail_code = ST_OVERFLOW;
    em_we     = 1'b0;
    em_byte   = 8'd0;
    em_cnt    = 16'd0;
    cm_fire   = 1'b0;
    cm_norm   = 1'b0;
    adv       = 1'b0;
    run_wr    = '{we: 1'b0, byte_v: 8'd0, cnt: 16'd0};

    unique case (st_r)
      S_IDLE: begin
        if (in_valid) begin
          kind_nxt  = kind_t'(in_kind);
          idx_nxt   = in_symbol_index;
          alpha_nxt = in_alphabet_size;
          below_nxt = in_cdf_below;
          at_nxt    = in_cdf_at;
          lit_nxt   = in_literal_value << (6'd32 - in_literal_bits);
          lb_nxt    = in_literal_bits;
          n_nxt     = '0;
          rd_nxt    = '0;
          st_nxt    = S_OUT;
          if (kind_t'(in_kind) == KIND_RST) begin
            low_nxt  = 64'd0;
            rng_nxt  = RANGE_INIT;
            cnt_nxt  = CNT_INIT;
            pos_nxt  = 32'd0;
            err_nxt  = ST_OK;
            fin_nxt  = 1'b0;
            held_nxt = 8'd0;
            hv_nxt   = 1'b0;
            ff_nxt   = 16'd0;
          end else if (err_r == ST_OK) begin
            unique case (kind_t'(in_kind))
              KIND_SYM: begin
                if (sym_bad) begin
                  fail_req  = 1'b1;
                  fail_code = ST_INVALID;
                end else begin
                  st_nxt = S_SYM_U;
                end
              end
              KIND_LIT: begin
                if (lit_bad) begin
                  fail_req  = 1'b1;
                  fail_code = ST_INVALID;
                end else if (in_literal_bits != 6'd0) begin
                  st_nxt = S_BOOL;
                end
              end
              KIND_FIN: begin
                if (fin_r) begin
                  fail_req  = 1'b1;
                  fail_code = ST_INVALID;
                end else begin
                  st_nxt = S_FIN;
                end
              end
              default: st_nxt = S_OUT;
            endcase
          end
        end
      end
      S_SYM_U: st_nxt = S_SYM_L;
      S_SYM_L: begin
        su_nxt = mul_q;
        st_nxt = S_SYM_C;
      end
      S_SYM_C: begin
        if (idx_r != 4'd0 && below_r != 16'd0) begin
          wl_nxt = low_r + {32'b0, {14{d_rs[17]}}, d_rs};
          wr_nxt = d_ss;
        end else begin
          wl_nxt = low_r;
          wr_nxt = d_ru;
        end
        st_nxt = S_NORM;
      end
      S_BOOL: st_nxt = S_BOOL_C;
      S_BOOL_C: begin
        if (lit_r[31]) begin
          wl_nxt = low_r + {32'b0, {14{d_rsp[17]}}, d_rsp};
          wr_nxt = {1'b0, mul_q};
        end else begin
          wl_nxt = low_r;
          wr_nxt = d_rsp;
        end
        st_nxt = S_NORM;
      end
      S_NORM: begin
        if (range_bad) begin
          fail_req = 1'b1;
          st_nxt   = S_OUT;
        end else if ($signed(pend_c) < $signed(NORM_LIMIT)) begin
          cm_fire = 1'b1;
          cm_norm = 1'b1;
        end else begin
          shift_nxt = sh_c;
          ready_nxt = ready_c;
          count_nxt = count_c[4:0];
          npend_nxt = pend_c - {2'b0, ready_c, 3'b000};
          st_nxt    = S_EXTR;
        end
      end
      S_EXTR: begin
        t_nxt  = wl_r >> count_r;
        wl_nxt = wl_r & mask_c;
        st_nxt = S_ROOM;
      end
      S_ROOM: begin
        if (room_ovf) begin
          fail_req = 1'b1;
          st_nxt   = S_OUT;
        end else if (room_small) begin
          fail_req  = 1'b1;
          fail_code = ST_SMALL;
          st_nxt    = S_OUT;
        end else if (t_r[{ready_r, 3'b000}] && !can_carry) begin
          fail_req = 1'b1;
          st_nxt   = S_OUT;
        end else if (sizing_r) begin
          cm_fire = 1'b1;
        end else begin
          bi_nxt = 3'd0;
          st_nxt = t_r[{ready_r, 3'b000}] ? S_CARRY : S_PUT;
        end
      end
      S_CARRY: begin
        if (ff_r != 16'd0) begin
          em_we   = 1'b1;
          em_byte = held_r + 8'd1;
          em_cnt  = 16'd1;
          st_nxt  = S_CARRY2;
        end else begin
          held_nxt = held_r + 8'd1;
          st_nxt   = S_PUT;
        end
      end
      S_CARRY2: begin
        if (ff_r > 16'd1) begin
          em_we   = 1'b1;
          em_byte = 8'd0;
          em_cnt  = ff_r - 16'd1;
        end
        held_nxt = 8'd0;
        ff_nxt   = 16'd0;
        st_nxt   = S_PUT;
      end
      S_PUT: begin
        if (put_v == BYTE_FF) begin
          if (ff_r >= 16'(MAX_FF_RUN)) begin
            fail_req = 1'b1;
            st_nxt   = S_OUT;
          end else begin
            ff_nxt = ff_r + 16'd1;
            adv    = 1'b1;
          end
        end else begin
          if (hv_r) begin
            em_we   = 1'b1;
            em_byte = held_r;
            em_cnt  = 16'd1;
          end
          st_nxt = S_PUT2;
        end
      end
      S_PUT2: begin
        if (ff_r != 16'd0) begin
          em_we   = 1'b1;
          em_byte = BYTE_FF;
          em_cnt  = ff_r;
        end
        held_nxt = put_v;
        hv_nxt   = 1'b1;
        ff_nxt   = 16'd0;
        adv      = 1'b1;
      end
      S_FIN: begin
        if (room_ovf) begin
          fail_req = 1'b1;
          st_nxt   = S_OUT;
        end else if (room_small) begin
          fail_req  = 1'b1;
          fail_code = ST_SMALL;
          st_nxt    = S_OUT;
        end else begin
          t_nxt     = fin_end;
          fcnt_nxt  = {cnt_r[6], cnt_r};
          fpend_nxt = pend_f;
          st_nxt    = S_FIN_LOOP;
        end
      end
      S_FIN_LOOP: begin
        if (fpend_r[7] || fpend_r == 8'd0) begin
          st_nxt = S_FIN_END;
        end else if (fval[8] && !can_carry) begin
          fail_req = 1'b1;
          st_nxt   = S_OUT;
        end else if (sizing_r) begin
          adv = 1'b1;
        end else begin
          fbyte_nxt = fval[7:0];
          st_nxt    = fval[8] ? S_CARRY : S_PUT;
        end
      end
      S_FIN_END: begin
        fin_nxt = 1'b1;
        if (!sizing_r && hv_r) begin
          em_we   = 1'b1;
          em_byte = held_r;
          em_cnt  = 16'd1;
        end
        st_nxt = S_FIN_END2;
      end
      S_FIN_END2: begin
        if (!sizing_r && ff_r != 16'd0) begin
          em_we   = 1'b1;
          em_byte = BYTE_FF;
          em_cnt  = ff_r;
        end
        hv_nxt   = 1'b0;
        held_nxt = 8'd0;
        ff_nxt   = 16'd0;
        st_nxt   = S_OUT;
      end
      S_OUT: begin
        if (out_ready) begin
          if (rd_r == n_r) begin
            st_nxt = S_IDLE;
          end else begin
            rd_nxt = rd_r + CNT_W'(1);
          end
        end
      end
      default: st_nxt = S_IDLE;
    endcase

    // byte advance
    if (adv) begin
      if (kind_r == KIND_FIN) begin
        pos_nxt   = pos_r + 32'd1;
        t_nxt     = t_r & mask_f;
        fpend_nxt = fpend_r - 8'd8;
        fcnt_nxt  = fcnt_r - 8'd8;
        st_nxt    = S_FIN_LOOP;
      end else if (bi_r == ready_r - 3'd1) begin
        cm_fire = 1'b1;
      end else begin
        bi_nxt = bi_r + 3'd1;
        st_nxt = S_PUT;
      end
    end

    // normalize commit and continue
    cm_sh = cm_norm ? sh_c : shift_r;
    if (cm_fire) begin
      low_nxt = wl_r << cm_sh;
      rng_nxt = wr_r[15:0] << cm_sh;
      if (cm_norm) begin
        cnt_nxt = pend_c[6:0];
      end else begin
        cnt_nxt = npend_r[6:0];
        pos_nxt = pos_r + {29'b0, ready_r};
      end
      if (kind_r == KIND_LIT && lb_r != 6'd1) begin
        lb_nxt  = lb_r - 6'd1;
        lit_nxt = lit_r << 1;
        st_nxt  = S_BOOL;
      end else begin
        st_nxt = S_OUT;
      end
    end

    // run queue write
    if (em_we) begin
      if (n_r >= CNT_W'(RUN_DEPTH)) begin
        fail_req  = 1'b1;
        fail_code = ST_OVERFLOW;
      end else begin
        run_wr = '{we: 1'b1, byte_v: em_byte, cnt: em_cnt};
        n_nxt  = n_r + CNT_W'(1);
      end
    end

    if (fail_req && err_r == ST_OK) begin
      err_nxt = fail_code;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= S_IDLE;
      sizing_r <= 1'b0;
      cap_r    <= 32'd0;
      low_r    <= 64'd0;
      rng_r    <= RANGE_INIT;
      cnt_r    <= CNT_INIT;
      pos_r    <= 32'd0;
      err_r    <= ST_OK;
      fin_r    <= 1'b0;
      held_r   <= 8'd0;
      hv_r     <= 1'b0;
      ff_r     <= 16'd0;
      n_r      <= '0;
      rd_r     <= '0;
    end else begin
      st_r   <= st_nxt;
      low_r  <= low_nxt;
      rng_r  <= rng_nxt;
      cnt_r  <= cnt_nxt;
      pos_r  <= pos_nxt;
      err_r  <= err_nxt;
      fin_r  <= fin_nxt;
      held_r <= held_nxt;
      hv_r   <= hv_nxt;
      ff_r   <= ff_nxt;
      n_r    <= n_nxt;
      rd_r   <= rd_nxt;
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_index))
          REG_SIZING:   sizing_r <= cfg_wdata[0];
          REG_CAPACITY: cap_r    <= cfg_wdata;
          default:      sizing_r <= sizing_r;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    idx_r   <= idx_nxt;
    alpha_r <= alpha_nxt;
    below_r <= below_nxt;
    at_r    <= at_nxt;
    lit_r   <= lit_nxt;
    lb_r    <= lb_nxt;
    wl_r    <= wl_nxt;
    wr_r    <= wr_nxt;
    su_r    <= su_nxt;
    shift_r <= shift_nxt;
    ready_r <= ready_nxt;
    count_r <= count_nxt;
    npend_r <= npend_nxt;
    t_r     <= t_nxt;
    bi_r    <= bi_nxt;
    fbyte_r <= fbyte_nxt;
    fcnt_r  <= fcnt_nxt;
    fpend_r <= fpend_nxt;
  end

  logic is_stat;
  assign is_stat           = (rd_r == n_r);
  assign in_ready          = (st_r == S_IDLE);
  assign out_valid         = (st_r == S_OUT);
  assign out_byte_value    = is_stat ? 8'd0 : run_rd.byte_v;
  assign out_repeat_count  = is_stat ? 16'd0 : run_rd.cnt;
  assign out_status        = is_stat ? err_r : ST_OK;
  assign out_byte_position = pos_r;
  assign out_last          = is_stat;

endmodule

### dv/tb_av1_multisymbol_range_encoder_unit.sv
// tb_av1_multisymbol_range_encoder_unit: self-checking testbench of the multi-symbol
// range encoder; a scoreboard class predicts byte runs and status, tasks drive requests
// depends on av1re_pkg and av1_multisymbol_range_encoder_unit
module tb_av1_multisymbol_range_encoder_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import av1re_pkg::*;

  localparam int MAX_FF_RUN = 65535;
  localparam int MAX_SYMBOLS = 16;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    kind_t       kind;
    bit [3:0]    sym_idx;
    bit [4:0]    alpha;
    bit [15:0]   cdf_lo;
    bit [15:0]   cdf_hi;
    bit [31:0]   lit_val;
    bit [5:0]    lit_bits;
  } enc_req_t;

  typedef struct {
    bit [7:0]    byte_v;
    bit [15:0]   cnt;
    status_t     st;
    bit [31:0]   pos;
    bit          is_last;
  } enc_res_t;

  class range_coder_scoreboard;
    bit          sizing;
    bit [31:0]   cap;
    bit [63:0]   low_w;
    bit [31:0]   rng_w;
    int          bits_w;
    bit [31:0]   pos;
    status_t     err;
    bit          fin;
    bit [7:0]    held;
    bit          held_v;
    int unsigned ff_run;
    enc_res_t    expected_q[$];
    enc_res_t    step_q[$];
    int          mismatches;
    int          runs_seen;
    int          status_seen;

    function new();
      sizing = 0;
      cap = 0;
      mismatches = 0;
      runs_seen = 0;
      status_seen = 0;
      clear();
    endfunction

    function void clear();
      low_w = 0;
      rng_w = 32'h8000;
      bits_w = -9;
      pos = 0;
      err = ST_OK;
      fin = 0;
      held = 0;
      held_v = 0;
      ff_run = 0;
    endfunction

    function void set_reg(reg_idx_t idx, bit [31:0] d);
      if (idx == REG_SIZING) sizing = d[0];
      else cap = d;
    endfunction

    function void flag(status_t s);
      if (err == ST_OK) err = s;
    endfunction

    function void push_run(bit [7:0] b, int unsigned n);
      enc_res_t r;
      if (step_q.size() >= RESULT_LIMIT - 1) begin
        flag(ST_OVERFLOW);
        return;
      end
      r = '{byte_v: b, cnt: n[15:0], st: ST_OK, pos: '0, is_last: 1'b0};
      step_q.push_back(r);
    endfunction

    function bit carry_ok();
      return sizing || (held_v && held != 8'hff);
    endfunction

    function void carry_in();
      if (ff_run > 0) begin
        push_run(held + 8'd1, 1);
        if (ff_run > 1) push_run(8'h00, ff_run - 1);
        held = 0;
        ff_run = 0;
      end else begin
        held = held + 8'd1;
      end
    endfunction

    function bit put(bit [7:0] v);
      if (v == 8'hff) begin
        if (ff_run >= MAX_FF_RUN) begin
          flag(ST_OVERFLOW);
          return 0;
        end
        ff_run++;
        return 1;
      end
      if (held_v) push_run(held, 1);
      if (ff_run > 0) push_run(8'hff, ff_run);
      held = v;
      held_v = 1;
      ff_run = 0;
      return 1;
    endfunction

    function bit room(int unsigned n);
      longint unsigned e;
      e = longint'(pos) + n;
      if (e > 64'hffff_ffff) begin
        flag(ST_OVERFLOW);
        return 0;
      end
      if (!sizing && e > cap) begin
        flag(ST_SMALL);
        return 0;
      end
      return 1;
    endfunction

    function bit renorm(bit [63:0] lo, bit [31:0] r);
      bit [31:0] tmp;
      int fl, sh, cnt, pend, rdy;
      bit [63:0] ob, cm;
      bit cy;
      if (r == 0 || r > 65535) begin
        flag(ST_OVERFLOW);
        return 0;
      end
      fl = 0;
      tmp = r;
      while (tmp > 1) begin
        tmp = tmp >> 1;
        fl++;
      end
      sh = 15 - fl;
      cnt = bits_w;
      pend = cnt + sh;
      if (pend >= 40) begin
        rdy = (pend >>> 3) + 1;
        if (rdy > 7) begin
          flag(ST_OVERFLOW);
          return 0;
        end
        cnt += 24 - rdy * 8;
        if (cnt < 0 || cnt >= 64) begin
          flag(ST_OVERFLOW);
          return 0;
        end
        ob = lo >> cnt;
        lo &= (64'd1 << cnt) - 1;
        cm = 64'd1 << (rdy * 8);
        cy = (ob & cm) != 0;
        ob &= cm - 1;
        if (!room(rdy)) return 0;
        if (cy && !carry_ok()) begin
          flag(ST_OVERFLOW);
          return 0;
        end
        if (!sizing) begin
          if (cy) carry_in();
          for (int i = 0; i < rdy; i++) begin
            if (!put(8'(ob >> ((rdy - i - 1) * 8)))) return 0;
          end
        end
        pos += rdy;
        pend = cnt + sh - 24;
      end
      low_w = lo << sh;
      rng_w = (r << sh) & 32'hffff;
      bits_w = pend;
      return 1;
    endfunction

    function void code_sym(enc_req_t q);
      bit [31:0] rg, r8, lower, upper, su, sl, lst, d;
      bit [63:0] lo;
      int idx, al;
      idx = q.sym_idx;
      al = q.alpha;
      if (fin || al < 2 || al > MAX_SYMBOLS || idx >= al || q.cdf_hi > 32768 ||
          (idx > 0 && (q.cdf_lo > 32768 || q.cdf_lo > q.cdf_hi)) ||
          (idx == al - 1 && q.cdf_hi != 32768)) begin
        flag(ST_INVALID);
        return;
      end
      rg = rng_w;
      r8 = rng_w >> 8;
      lo = low_w;
      lst = al - 1;
      lower = (idx == 0) ? 32'd32768 : 32'd32768 - q.cdf_lo;
      upper = 32'd32768 - q.cdf_hi;
      su = ((r8 * (upper >> 6)) >> 1) + 4 * (lst - idx);
      if (lower < 32768) begin
        sl = ((r8 * (lower >> 6)) >> 1) + 4 * (lst - idx + 1);
        d = rg - sl;
        lo += {32'd0, d};
        rg = sl - su;
      end else begin
        rg = rg - su;
      end
      void'(renorm(lo, rg));
    endfunction

    function bit code_bool(bit b);
      bit [31:0] rg, split, d;
      bit [63:0] lo;
      rg = rng_w;
      lo = low_w;
      split = (((rg >> 8) * 32'd256) >> 1) + 4;
      d = rg - split;
      if (b) lo += {32'd0, d};
      rg = b ? split : d;
      return renorm(lo, rg);
    endfunction

    function void code_lit(enc_req_t q);
      int nb;
      nb = q.lit_bits;
      if (fin || nb > 32 || (nb != 0 && nb < 32 && (q.lit_val >> nb) != 0)) begin
        flag(ST_INVALID);
        return;
      end
      for (int i = 0; i < nb; i++) begin
        if (!code_bool(q.lit_val[nb - i - 1])) return;
      end
    endfunction

    function void finish_stream();
      int cnt, pend, sh;
      int unsigned nb;
      bit [63:0] fw;
      bit [15:0] v;
      bit cy;
      cnt = bits_w;
      pend = bits_w + 10;
      nb = (pend > 0) ? ((pend + 7) >> 3) : 0;
      if (fin) begin
        flag(ST_INVALID);
        return;
      end
      if (!room(nb)) return;
      fw = ((low_w + 64'h3fff) & ~64'h3fff) | 64'h4000;
      while (pend > 0) begin
        if (cnt < -15 || cnt > 47) begin
          flag(ST_OVERFLOW);
          return;
        end
        sh = cnt + 16;
        v = 16'(fw >> sh);
        cy = v[8];
        if (cy && !carry_ok()) begin
          flag(ST_OVERFLOW);
          return;
        end
        if (!sizing) begin
          if (cy) carry_in();
          if (!put(v[7:0])) return;
        end
        pos++;
        fw &= (64'd1 << sh) - 1;
        pend -= 8;
        cnt -= 8;
      end
      fin = 1;
      if (!sizing) begin
        if (held_v) push_run(held, 1);
        if (ff_run > 0) push_run(8'hff, ff_run);
      end
      held_v = 0;
      held = 0;
      ff_run = 0;
    endfunction

    function void note_request(enc_req_t q);
      enc_res_t r;
      step_q.delete();
      if (q.kind == KIND_RST) clear();
      else if (err == ST_OK) begin
        case (q.kind)
          KIND_SYM: code_sym(q);
          KIND_LIT: code_lit(q);
          default:  finish_stream();
        endcase
      end
      r = '{byte_v: 8'd0, cnt: 16'd0, st: err, pos: '0, is_last: 1'b1};
      step_q.push_back(r);
      foreach (step_q[i]) begin
        step_q[i].pos = pos;
        expected_q.push_back(step_q[i]);
      end
    endfunction

    function void report(string what, longint got, longint want);
      $display("mismatch %0s: got %0h expected %0h", what, got, want);
      mismatches++;
    endfunction

    function void check_result(enc_res_t g);
      enc_res_t w;
      if (expected_q.size() == 0) begin
        report("unexpected result", g.byte_v, 0);
        return;
      end
      w = expected_q.pop_front();
      if (w.is_last) status_seen++;
      else runs_seen++;
      if (g.byte_v != w.byte_v) report("byte_value", g.byte_v, w.byte_v);
      if (g.cnt != w.cnt) report("repeat_count", g.cnt, w.cnt);
      if (g.st != w.st) report("status", g.st, w.st);
      if (g.pos != w.pos) report("byte_position", g.pos, w.pos);
      if (g.is_last != w.is_last) report("last", g.is_last, w.is_last);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [0:0]  cfg_index;
  logic [31:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic [1:0]  in_kind;
  logic [3:0]  in_symbol_index;
  logic [4:0]  in_alphabet_size;
  logic [15:0] in_cdf_below;
  logic [15:0] in_cdf_at;
  logic [31:0] in_literal_value;
  logic [5:0]  in_literal_bits;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_byte_value;
  logic [15:0] out_repeat_count;
  logic [1:0]  out_status;
  logic [31:0] out_byte_position;
  logic        out_last;

  range_coder_scoreboard sb;
  int cycles;
  int sent;
  int stall;
  bit quiet;

  av1_multisymbol_range_encoder_unit dut (.*);

  initial clk = 0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb_av1_multisymbol_range_encoder_unit: FAIL");
      $finish;
    end
  end

  function int draw_gap();
    if (quiet || $urandom_range(0, 3) == 0) return 0;
    return $urandom_range(0, 14);
  endfunction

  // result side: check each accepted result, then stall at random
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        sb.check_result('{byte_v: out_byte_value, cnt: out_repeat_count,
                          st: status_t'(out_status), pos: out_byte_position,
                          is_last: out_last});
        stall = draw_gap();
      end
      if (stall > 0) begin
        stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic send(enc_req_t q);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_kind <= q.kind;
    in_symbol_index <= q.sym_idx;
    in_alphabet_size <= q.alpha;
    in_cdf_below <= q.cdf_lo;
    in_cdf_at <= q.cdf_hi;
    in_literal_value <= q.lit_val;
    in_literal_bits <= q.lit_bits;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    sb.note_request(q);
    sent++;
  endtask

  task automatic write_reg(reg_idx_t idx, bit [31:0] d);
    in_valid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (40) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= d;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_reg(idx, d);
  endtask

  function automatic enc_req_t mk(kind_t k, int idx, int al, int lo, int hi,
                                  bit [31:0] v, int nb);
    enc_req_t q;
    q.kind = k;
    q.sym_idx = 4'(idx);
    q.alpha = 5'(al);
    q.cdf_lo = 16'(lo);
    q.cdf_hi = 16'(hi);
    q.lit_val = v;
    q.lit_bits = 6'(nb);
    return q;
  endfunction

  function automatic enc_req_t noise();
    return mk(kind_t'($urandom_range(0, 3)), $urandom_range(0, 15), $urandom_range(0, 31),
              $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom(),
              $urandom_range(0, 63));
  endfunction

  function automatic enc_req_t good_sym();
    int al, idx, hi, lo;
    al = $urandom_range(2, MAX_SYMBOLS);
    idx = $urandom_range(0, al - 1);
    hi = (idx == al - 1) ? 32768 : $urandom_range(0, 32768);
    lo = (idx == 0) ? $urandom_range(0, 65535) : $urandom_range(0, hi);
    return mk(KIND_SYM, idx, al, lo, hi, $urandom(), $urandom_range(0, 63));
  endfunction

  function automatic enc_req_t good_lit();
    int nb;
    bit [31:0] v;
    nb = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32) : $urandom_range(1, 8);
    v = $urandom();
    if (nb < 32) v = v & ((32'd1 << nb) - 1);
    return mk(KIND_LIT, $urandom_range(0, 15), $urandom_range(0, 31),
              $urandom_range(0, 65535), $urandom_range(0, 65535), v, nb);
  endfunction

  task automatic run_streams(int n);
    int stop, len;
    stop = sent + n;
    while (sent < stop) begin
      quiet = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 7) != 0) send(mk(KIND_RST, 0, 2, 0, 0, 0, 0));
      len = $urandom_range(1, 15);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 9) == 0) send(noise());
        else if ($urandom_range(0, 2) == 0) send(good_lit());
        else send(good_sym());
      end
      if ($urandom_range(0, 9) != 0) send(mk(KIND_FIN, 0, 2, 0, 0, 0, 0));
    end
  endtask

  initial begin
    sb = new();
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= REG_SIZING;
    cfg_wdata <= '0;
    in_valid <= 1'b0;
    in_kind <= KIND_RST;
    in_symbol_index <= '0;
    in_alphabet_size <= '0;
    in_cdf_below <= '0;
    in_cdf_at <= '0;
    in_literal_value <= '0;
    in_literal_bits <= '0;
    out_ready <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(REG_SIZING, 32'd0);
    write_reg(REG_CAPACITY, 32'hffff_ffff);

    // directed: bounds, each kind and the error paths
    send(mk(KIND_SYM, 0, 2, 65535, 16384, 0, 0));
    send(mk(KIND_SYM, 15, 16, 0, 32768, 0, 0));
    send(mk(KIND_SYM, 3, 8, 32768, 32768, 0, 0));
    send(mk(KIND_SYM, 0, 16, 0, 0, 0, 0));
    send(mk(KIND_LIT, 0, 0, 0, 0, 32'h0, 0));
    send(mk(KIND_LIT, 0, 0, 0, 0, 32'hffff_ffff, 32));
    send(mk(KIND_LIT, 0, 0, 0, 0, 32'h5, 3));
    send(mk(KIND_FIN, 0, 0, 0, 0, 0, 0));
    send(mk(KIND_FIN, 0, 0, 0, 0, 0, 0));
    send(mk(KIND_SYM, 0, 2, 0, 100, 0, 0));
    send(mk(KIND_RST, 0, 0, 0, 0, 0, 0));
    send(mk(KIND_SYM, 0, 1, 0, 100, 0, 0));
    send(mk(KIND_RST, 0, 0, 0, 0, 0, 0));
    send(mk(KIND_SYM, 0, 31, 0, 100, 0, 0));
    send(mk(KIND_RST, 0, 0, 0, 0, 0, 0));
    send(mk(KIND_SYM, 5, 4, 0, 32768, 0, 0));
    send(mk(KIND_RST, 0, 0, 0, 0, 0, 0));
    send(mk(KIND_SYM, 1, 4, 200, 100, 0, 0));
    send(mk(KIND_RST, 0, 0, 0, 0, 0, 0));
    send(mk(KIND_SYM, 3, 4, 100, 65535, 0, 0));
    send(mk(KIND_RST, 0, 0, 0, 0, 0, 0));
    send(mk(KIND_LIT, 0, 0, 0, 0, 32'h8, 3));
    send(mk(KIND_RST, 0, 0, 0, 0, 0, 0));
    send(mk(KIND_LIT, 0, 0, 0, 0, 32'h1, 63));

    run_streams(70);
    write_reg(REG_SIZING, 32'd1);
    write_reg(REG_CAPACITY, 32'd0);
    run_streams(60);
    write_reg(REG_SIZING, 32'd0);
    write_reg(REG_CAPACITY, $urandom_range(3, 24));
    run_streams(70);
    write_reg(REG_CAPACITY, 32'd0);
    run_streams(30);
    write_reg(REG_SIZING, 32'd1);
    write_reg(REG_CAPACITY, 32'hffff_ffff);
    run_streams(50);
    write_reg(REG_SIZING, 32'd0);
    run_streams(100);

    in_valid <= 1'b0;
    while (sb.expected_q.size() > 0) @(posedge clk);
    repeat (50) @(posedge clk);
    $display("sent %0d requests over six register settings; checked %0d byte runs",
             sent, sb.runs_seen);
    $display("and %0d status results, %0d mismatches", sb.status_seen, sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("tb_av1_multisymbol_range_encoder_unit: PASS");
    end else begin
      $display("tb_av1_multisymbol_range_encoder_unit: FAIL");
    end
    $finish;
  end

endmodule
